// File: rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, constants and helpers of the ratchet step sequencer.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int STEP_COUNT_DEF   = 16;
    localparam int MAX_RATCHETS_DEF = 4;

    localparam int LEN_W      = 24;
    localparam int CNT_W      = 16;
    localparam int STEP_NUM_W = 4;
    localparam int SLICE_W    = 4;
    localparam int RAT_FLD_W  = 3;
    localparam int RAT_W      = 4;
    localparam int CHANCE_W   = 9;
    localparam int PITCH_W    = 7;
    localparam int ROLL_W     = 8;
    localparam int SHOW_W     = 4;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [LEN_W-1:0]    STEP_LENGTH_RESET = 24'd1536000;
    localparam logic [CHANCE_W-1:0] CHANCE_ALWAYS     = 9'd256;
    localparam logic [PITCH_W-1:0]  PITCH_MAX         = 7'd48;
    localparam logic [PITCH_W-1:0]  PITCH_MIN         = 7'b1010000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STEP_LENGTH = 1'b0,
        CFG_RUNNING     = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_TICK  = 1'b0,
        MODE_WRITE = 1'b1
    } mode_t;

    typedef struct packed {
        logic [PITCH_W-1:0]   pitch;
        logic                 reverse;
        logic [CHANCE_W-1:0]  chance;
        logic [RAT_FLD_W-1:0] ratchets;
        logic [SLICE_W-1:0]   slice;
        logic                 active;
    } step_entry_t;

    // packed so that fire lands in bit 0 of the output word
    typedef struct packed {
        logic [SHOW_W-1:0]  current_step;
        logic [PITCH_W-1:0] pitch;
        logic               reverse;
        logic [SLICE_W-1:0] slice;
        logic               fire;
    } result_t;

    function automatic step_entry_t default_entry(input logic [SLICE_W-1:0] idx);
        step_entry_t e;
        e          = '0;
        e.slice    = idx;
        e.ratchets = 3'd1;
        e.chance   = CHANCE_ALWAYS;
        return e;
    endfunction

    function automatic logic [PITCH_W-1:0] clamp_pitch(input logic [PITCH_W-1:0] p);
        logic [PITCH_W-1:0] r;
        r = p;
        if ($signed(p) > $signed(PITCH_MAX)) begin
            r = PITCH_MAX;
        end else if ($signed(p) < $signed(PITCH_MIN)) begin
            r = PITCH_MIN;
        end
        return r;
    endfunction

endpackage

// File: rtl/rss_step_table.sv
// ----------------------------------------------------------------------------
// rss_step_table
// Step entry memory with per-entry valid bits and a registered read port.
// ----------------------------------------------------------------------------
module rss_step_table #(
    parameter int STEP_COUNT = rss_pkg::STEP_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [$clog2(STEP_COUNT)-1:0] wr_idx,
    input  rss_pkg::step_entry_t          wr_entry,
    input  logic [$clog2(STEP_COUNT)-1:0] rd_addr_next,
    output rss_pkg::step_entry_t          rd_entry
);

    localparam int POS_W = $clog2(STEP_COUNT);

    rss_pkg::step_entry_t     mem_array [STEP_COUNT];
    logic [STEP_COUNT-1:0]    valid_reg;
    rss_pkg::step_entry_t     rd_data_reg;
    logic                     rd_valid_reg;
    logic [POS_W-1:0]         rd_addr_reg;
    logic                     bypass;

    // a write to the entry being fetched is forwarded
    assign bypass = wr_en && (wr_idx == rd_addr_next);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_idx] <= wr_entry;
        end
        rd_data_reg <= bypass ? wr_entry : mem_array[rd_addr_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            rd_valid_reg <= bypass || valid_reg[rd_addr_next];
            rd_addr_reg  <= rd_addr_next;
        end
    end

    // never written entries read as the cleared pattern
    assign rd_entry = rd_valid_reg ? rd_data_reg
                                   : rss_pkg::default_entry(rss_pkg::SLICE_W'(rd_addr_reg));

endmodule

// File: rtl/rss_ratchet_match.sv
// ----------------------------------------------------------------------------
// rss_ratchet_match
// Checks whether the sample count hits one of the ratchet offsets of a step.
// ----------------------------------------------------------------------------
module rss_ratchet_match #(
    parameter int MAX_RATCHETS = rss_pkg::MAX_RATCHETS_DEF
) (
    input  logic [rss_pkg::CNT_W-1:0]     sample_count,
    input  logic [rss_pkg::LEN_W-1:0]     step_length,
    input  logic [rss_pkg::RAT_FLD_W-1:0] ratchets,
    output logic                          hit
);

    localparam int PROD_W = 28;
    localparam int SCR_W  = rss_pkg::CNT_W + rss_pkg::RAT_W;
    localparam logic [rss_pkg::RAT_W-1:0] MAX_RAT = rss_pkg::RAT_W'(MAX_RATCHETS);

    logic [rss_pkg::RAT_W-1:0] raw;
    logic [rss_pkg::RAT_W-1:0] rat;
    logic [SCR_W-1:0]          sc_x_rat;
    logic [PROD_W-1:0]         win_lo;
    logic [PROD_W-1:0]         win_hi;
    logic [MAX_RATCHETS-1:0]   lane_hit;

    assign raw = {1'b0, ratchets};

    always_comb begin
        rat = raw;
        if (raw == '0) begin
            rat = rss_pkg::RAT_W'(1);
        end else if (raw > MAX_RAT) begin
            rat = MAX_RAT;
        end
    end

    // offset r hits when count*rat*256 <= r*len < (count+1)*rat*256
    assign sc_x_rat = SCR_W'(sample_count) * SCR_W'(rat);
    assign win_lo   = {sc_x_rat, 8'b0};
    assign win_hi   = win_lo + PROD_W'({rat, 8'b0});

    for (genvar lane = 0; lane < MAX_RATCHETS; lane++) begin : g_lane
        logic [PROD_W-1:0] lane_off;
        assign lane_off       = PROD_W'(step_length) * PROD_W'(lane);
        assign lane_hit[lane] = (rss_pkg::RAT_W'(lane) < rat)
                                && (lane_off >= win_lo) && (lane_off < win_hi);
    end

    assign hit = |lane_hit;

endmodule

// File: rtl/ratchet_step_sequencer_top.sv
// ----------------------------------------------------------------------------
// ratchet_step_sequencer_top
// Sixteen-step ratchet trigger sequencer driven by one word per audio sample.
// ----------------------------------------------------------------------------
// Input words on s_: tuser 0 is a sample tick, tuser 1 writes one step entry.
// Every accepted word gives exactly one output word on m_ carrying the
// trigger (fire flag, slice, reverse, pitch) and the step position.
// Configuration: cfg_addr 0 sets the Q16.8 step length, cfg_addr 1 the
// running flag; write only while no word is in flight.
// The result word is registered on acceptance and is valid on m_ in the next cycle.
// Throughput: one word per cycle unless a held result stalls the input; a tick is resolved
// in a single pass through a 16x4 multiply and the per-ratchet window compares, and the step
// entry comes from a registered table read prefetched at the next position.
// Reset: position, sample count and held step clear, the table reads as the
// cleared pattern (inactive, slice equals index, one ratchet) at once,
// step length returns to 1536000 and running to 0.
// Stall: one output register; s_tready stays high while it is empty or
// being drained, so a held result blocks input for as long as m_tready is low.
// ----------------------------------------------------------------------------
module ratchet_step_sequencer_top #(
    parameter int STEP_COUNT   = rss_pkg::STEP_COUNT_DEF,
    parameter int MAX_RATCHETS = rss_pkg::MAX_RATCHETS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // step_number, step_active, step_slice, step_ratchets, step_chance,
    // step_reverse, step_pitch, random_roll, zero fill
    input  logic [rss_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // trigger_fire, trigger_slice, trigger_reverse, trigger_pitch,
    // current_step, zero fill
    output logic [rss_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [rss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int POS_W = $clog2(STEP_COUNT);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(STEP_COUNT - 1);
    localparam int RES_W = $bits(rss_pkg::result_t);

    // input word fields
    logic [rss_pkg::STEP_NUM_W-1:0] in_step_number;
    rss_pkg::step_entry_t           in_entry;
    logic [rss_pkg::ROLL_W-1:0]     in_roll;

    // state
    logic [rss_pkg::LEN_W-1:0] step_length_reg, step_length_next;
    logic                      running_reg, running_next;
    logic [POS_W-1:0]          step_position_reg, step_position_next;
    logic [rss_pkg::CNT_W-1:0] sample_count_reg, sample_count_next;
    rss_pkg::step_entry_t      held_entry_reg, held_entry_next;
    logic                      step_passed_reg, step_passed_next;
    rss_pkg::result_t          result_reg, result_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    logic                      s_acc;
    logic                      tick_run;
    logic                      step_first;
    logic                      step_end;
    logic                      wr_en;
    logic [POS_W-1:0]          wr_idx;
    rss_pkg::step_entry_t      tbl_entry;
    rss_pkg::step_entry_t      entry_now;
    logic                      passed_now;
    logic                      ratchet_hit;
    logic                      fire;
    logic [rss_pkg::CNT_W:0]   count_inc;

    assign in_step_number    = s_tdata[3:0];
    assign in_entry.active   = s_tdata[4];
    assign in_entry.slice    = s_tdata[8:5];
    assign in_entry.ratchets = s_tdata[11:9];
    assign in_entry.chance   = s_tdata[20:12];
    assign in_entry.reverse  = s_tdata[21];
    assign in_entry.pitch    = rss_pkg::clamp_pitch(s_tdata[28:22]);
    assign in_roll           = s_tdata[36:29];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign tick_run = s_acc && (s_tuser == rss_pkg::MODE_TICK) && running_reg;

    assign wr_en  = s_acc && (s_tuser == rss_pkg::MODE_WRITE)
                    && (32'(in_step_number) < 32'(STEP_COUNT));
    assign wr_idx = POS_W'(in_step_number);

    rss_step_table #(
        .STEP_COUNT (STEP_COUNT)
    ) u_table (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .wr_en        (wr_en),
        .wr_idx       (wr_idx),
        .wr_entry     (in_entry),
        .rd_addr_next (step_position_next),
        .rd_entry     (tbl_entry)
    );

    // the tick that opens a step latches its entry and rolls the chance
    assign step_first = (sample_count_reg == '0);
    assign entry_now  = step_first ? tbl_entry : held_entry_reg;
    assign passed_now = step_first
                        ? (tbl_entry.active && ({1'b0, in_roll} < tbl_entry.chance))
                        : step_passed_reg;

    rss_ratchet_match #(
        .MAX_RATCHETS (MAX_RATCHETS)
    ) u_match (
        .sample_count (sample_count_reg),
        .step_length  (step_length_reg),
        .ratchets     (entry_now.ratchets),
        .hit          (ratchet_hit)
    );

    assign fire      = tick_run && passed_now && ratchet_hit;
    assign count_inc = {1'b0, sample_count_reg} + 1'b1;
    assign step_end  = {count_inc, 8'b0} >= {1'b0, step_length_reg};

    always_comb begin
        step_length_next = step_length_reg;
        running_next     = running_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                rss_pkg::CFG_STEP_LENGTH: step_length_next = cfg_wdata[rss_pkg::LEN_W-1:0];
                rss_pkg::CFG_RUNNING:     running_next     = cfg_wdata[0];
                default:                  running_next     = running_reg;
            endcase
        end
    end

    always_comb begin
        step_position_next = step_position_reg;
        sample_count_next  = sample_count_reg;
        held_entry_next    = held_entry_reg;
        step_passed_next   = step_passed_reg;
        if (tick_run) begin
            held_entry_next  = entry_now;
            step_passed_next = passed_now;
            if (step_end) begin
                sample_count_next  = '0;
                step_position_next = (step_position_reg == POS_LAST)
                                     ? '0 : step_position_reg + 1'b1;
            end else begin
                sample_count_next = count_inc[rss_pkg::CNT_W-1:0];
            end
        end
    end

    always_comb begin
        result_next              = '0;
        result_next.fire         = fire;
        result_next.current_step = rss_pkg::SHOW_W'(step_position_reg);
        if (fire) begin
            result_next.slice   = entry_now.slice;
            result_next.reverse = entry_now.reverse;
            result_next.pitch   = entry_now.pitch;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_acc) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_length_reg   <= rss_pkg::STEP_LENGTH_RESET;
            running_reg       <= 1'b0;
            step_position_reg <= '0;
            sample_count_reg  <= '0;
            held_entry_reg    <= '0;
            step_passed_reg   <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            step_length_reg   <= step_length_next;
            running_reg       <= running_next;
            step_position_reg <= step_position_next;
            sample_count_reg  <= sample_count_next;
            held_entry_reg    <= held_entry_next;
            step_passed_reg   <= step_passed_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(rss_pkg::M_TDATA_W - RES_W)'(0), result_reg};

    // assertions
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(step_position_reg) < 32'(STEP_COUNT))
        else $error("step position out of range");

    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !result_reg.fire |->
            result_reg.slice == '0 && result_reg.reverse == 1'b0 && result_reg.pitch == '0)
        else $error("trigger fields set without a trigger");

    a_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser == rss_pkg::MODE_TICK) && !running_reg && !cfg_wr_en |=>
            $stable(step_position_reg) && $stable(sample_count_reg))
        else $error("frozen tick moved the sequencer");

    a_step_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_run && step_end |=> sample_count_reg == '0)
        else $error("sample count not cleared at step end");

endmodule
